FILE: rtl/core/u16u8_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_pkg
// shared types and constants of the utf-16be to utf-8 transcoder
// ----------------------------------------------------------------------------
package u16u8_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;
    localparam int unsigned CP_W            = 21;

    localparam logic [7:0]  BOM_HI   = 8'hFE;
    localparam logic [7:0]  BOM_LO   = 8'hFF;
    localparam logic [15:0] REPL_CP  = 16'hFFFD;
    localparam logic [5:0]  LEAD_SUR = 6'b110110;
    localparam logic [5:0]  TRAIL_SUR = 6'b110111;
    localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       raw_code;
        logic       run_end;
    } t_out_item;

    // one queue entry: what a single input byte asks the back end to emit
    typedef enum logic [1:0] {
        JOB_RAW1,
        JOB_RAW2,
        JOB_CP
    } t_job_kind;

    typedef struct packed {
        t_job_kind       kind;
        logic [7:0]      raw_b;
        logic [CP_W-1:0] cp;
    } t_job;

endpackage
`default_nettype wire

FILE: rtl/core/u16u8_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_queue
// small first-in first-out queue between front end and back end
// ----------------------------------------------------------------------------
module u16u8_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/u16u8_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_front
// takes source bytes, tracks the byte order mark, code unit assembly and
// surrogate pairing, and hands one job per productive byte to the queue
// ----------------------------------------------------------------------------
module u16u8_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire u16u8_pkg::t_in_item i_in_item,
    input  wire logic                i_queue_full,
    output logic                     o_in_stall,
    output logic                     o_job_push,
    output u16u8_pkg::t_job          o_job
);

    import u16u8_pkg::*;

    typedef enum logic [1:0] {
        PH_START,
        PH_MARK,
        PH_RAW,
        PH_BODY
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_held, n_held;
    logic        r_have, n_have;
    logic        r_pend, n_pend;
    logic [9:0]  r_bits, n_bits;

    logic        accept;
    logic [7:0]  b;
    logic        last;
    logic        unit_go;
    logic [15:0] unit_code;
    t_job        job;
    logic        job_valid;

    assign b          = i_in_item.in_byte;
    assign last       = i_in_item.end_of_string;
    assign o_in_stall = i_queue_full;
    assign accept     = i_in_valid && !i_queue_full;
    assign o_job      = job;
    assign o_job_push = job_valid;

    always_comb begin
        n_phase   = r_phase;
        n_held    = r_held;
        n_have    = r_have;
        n_pend    = r_pend;
        n_bits    = r_bits;
        unit_go   = 1'b0;
        unit_code = {r_held, b};
        job.kind  = JOB_RAW1;
        job.raw_b = b;
        job.cp    = '0;
        job_valid = 1'b0;

        if (accept) begin
            unique case (r_phase)
                PH_START: begin
                    if (b == BOM_HI && !last) begin
                        n_phase = PH_MARK;
                    end else begin
                        job_valid = 1'b1;
                        n_phase   = PH_RAW;
                    end
                end
                PH_MARK: begin
                    if (b == BOM_LO) begin
                        n_phase = PH_BODY;
                    end else begin
                        job.kind  = JOB_RAW2;
                        job_valid = 1'b1;
                        n_phase   = PH_RAW;
                    end
                end
                PH_RAW: begin
                    job_valid = 1'b1;
                end
                PH_BODY: begin
                    if (r_have) begin
                        n_have  = 1'b0;
                        n_held  = '0;
                        unit_go = 1'b1;
                    end else if (last) begin
                        // odd byte at the end stands for a replacement char
                        unit_code = REPL_CP;
                        unit_go   = 1'b1;
                    end else begin
                        n_held = b;
                        n_have = 1'b1;
                    end
                end
            endcase

            if (unit_go) begin
                if (r_pend) begin
                    job.kind  = JOB_CP;
                    job_valid = 1'b1;
                    if (unit_code[15:10] == TRAIL_SUR) begin
                        job.cp = SUPP_BASE + {1'b0, r_bits, unit_code[9:0]};
                    end else begin
                        job.cp = {5'b0, REPL_CP};
                    end
                    n_pend = 1'b0;
                    n_bits = '0;
                end else if (unit_code[15:10] == LEAD_SUR) begin
                    n_pend = 1'b1;
                    n_bits = unit_code[9:0];
                end else begin
                    job.kind  = JOB_CP;
                    job.cp    = {5'b0, unit_code};
                    job_valid = 1'b1;
                end
            end

            if (last) begin
                n_phase = PH_START;
                n_held  = '0;
                n_have  = 1'b0;
                n_pend  = 1'b0;
                n_bits  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_held  <= '0;
            r_have  <= 1'b0;
            r_pend  <= 1'b0;
            r_bits  <= '0;
        end else begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_have  <= n_have;
            r_pend  <= n_pend;
            r_bits  <= n_bits;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/u16u8_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_back
// walks the job at the queue head one output byte per cycle into an output
// register while the output is not stalled
// ----------------------------------------------------------------------------
module u16u8_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_job_valid,
    input  wire u16u8_pkg::t_job  i_job,
    output logic                  o_job_pop,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output u16u8_pkg::t_out_item  o_out_item
);

    import u16u8_pkg::*;

    logic [1:0] r_idx, n_idx;
    logic       r_out_valid;
    t_out_item  r_out;
    t_out_item  cur;
    logic [1:0] last_idx;
    logic [1:0] grp;
    logic       out_free;
    logic       take;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign take        = out_free && i_job_valid;
    assign o_job_pop   = take && (r_idx == last_idx);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign grp         = last_idx - r_idx;

    // number of bytes minus one for the head job
    always_comb begin
        unique case (i_job.kind)
            JOB_RAW1: last_idx = 2'd0;
            JOB_RAW2: last_idx = 2'd1;
            JOB_CP: begin
                if (i_job.cp < 21'h80) begin
                    last_idx = 2'd0;
                end else if (i_job.cp < 21'h800) begin
                    last_idx = 2'd1;
                end else if (i_job.cp < 21'h10000) begin
                    last_idx = 2'd2;
                end else begin
                    last_idx = 2'd3;
                end
            end
            default: last_idx = 2'd0;
        endcase
    end

    always_comb begin
        cur.raw_code = 1'b1;
        cur.run_end  = (r_idx == last_idx);
        cur.out_byte = i_job.raw_b;
        unique case (i_job.kind)
            JOB_RAW1: cur.out_byte = i_job.raw_b;
            JOB_RAW2: cur.out_byte = (r_idx == 2'd0) ? BOM_HI : i_job.raw_b;
            JOB_CP: begin
                cur.raw_code = 1'b0;
                if (r_idx == 2'd0) begin
                    unique case (last_idx)
                        2'd0: cur.out_byte = {1'b0, i_job.cp[6:0]};
                        2'd1: cur.out_byte = {3'b110, i_job.cp[10:6]};
                        2'd2: cur.out_byte = {4'b1110, i_job.cp[15:12]};
                        2'd3: cur.out_byte = {5'b11110, i_job.cp[20:18]};
                    endcase
                end else begin
                    // continuation byte, six bits per group from the top down
                    case (grp)
                        2'd1:    cur.out_byte = {2'b10, i_job.cp[11:6]};
                        2'd2:    cur.out_byte = {2'b10, i_job.cp[17:12]};
                        default: cur.out_byte = {2'b10, i_job.cp[5:0]};
                    endcase
                end
            end
            default: cur.out_byte = i_job.raw_b;
        endcase
    end

    always_comb begin
        n_idx = r_idx;
        if (take) begin
            n_idx = (r_idx == last_idx) ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (out_free) begin
                r_out_valid <= i_job_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= cur;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/utf16be_to_utf8_transcoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf16be_to_utf8_transcoder_core
// utf-16be (after an fe ff mark) to utf-8 byte stream, raw pass-through else
// ----------------------------------------------------------------------------
// path: each job is registered in the job queue, and each result byte then in
//   the back end output register before it is valid
// throughput: one input transfer per cycle while the job queue has room (input
//   stalls whenever the queue is full); the back end emits one output byte per
//   cycle while the output is not stalled, and an item yields 0 to 4 bytes
// reset: synchronous active low, clears string state, queue and output valid
module utf16be_to_utf8_transcoder_core #(
    parameter int unsigned QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire u16u8_pkg::t_in_item  i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output u16u8_pkg::t_out_item      o_out_item
);

    import u16u8_pkg::*;

    localparam int unsigned JOB_W = $bits(t_job);

    t_job             push_job;
    logic             push;
    logic             q_full;
    logic             q_valid;
    logic             pop;
    logic [JOB_W-1:0] q_data;
    t_job             head_job;

    assign head_job = t_job'(q_data);

    u16u8_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_item    (i_in_item),
        .i_queue_full (q_full),
        .o_in_stall   (o_in_stall),
        .o_job_push   (push),
        .o_job        (push_job)
    );

    u16u8_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (JOB_W'(push_job)),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    u16u8_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (head_job),
        .o_job_pop   (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire
